### rtl/lag_pkg.sv
// ----------------------------------------------------------------------------
// lag_pkg
// Shared types, constants and helpers of the life automaton grid.
// ----------------------------------------------------------------------------
package lag_pkg;

  localparam int MaxColsDef = 64;
  localparam int MaxRowsDef = 64;

  // configuration register width and the wider width used for grid sizes
  localparam int CfgW = 7;
  localparam int DimW = 9;

  localparam logic [CfgW-1:0] CfgDimRst = 7'd64;

  // neighbor counts of the b3/s23 rule
  localparam logic [3:0] LiveBorn = 4'd3;
  localparam logic [3:0] LiveKeep = 4'd2;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_READ    = 2'd1,
    OP_ADVANCE = 2'd2
  } op_e;

  typedef enum logic {
    REG_GRID_WIDTH  = 1'b0,
    REG_GRID_HEIGHT = 1'b1
  } reg_idx_e;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } ctl_state_e;

  // control word from the sequencer to the rule unit
  typedef struct packed {
    logic             row_active;
    logic [DimW-1:0]  used_cols;
  } rule_ctl_t;

  // clamp a register value to the synthesized maximum
  function automatic logic [DimW-1:0] clamp_dim(logic [CfgW-1:0] v, logic [DimW-1:0] lim);
    logic [DimW-1:0] ext;
    ext = DimW'(v);
    return (ext > lim) ? lim : ext;
  endfunction

endpackage

### rtl/lag_row_cell.sv
// ----------------------------------------------------------------------------
// lag_row_cell
// One row of the grid; takes the row of its neighbor on every shift.
// ----------------------------------------------------------------------------
module lag_row_cell import lag_pkg::*; #(
  parameter int MAX_COLS = MaxColsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                shift_i,
  input  logic [MAX_COLS-1:0] row_i,
  output logic [MAX_COLS-1:0] row_o
);

  logic [MAX_COLS-1:0] row_q, row_d;

  assign row_d = shift_i ? row_i : row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
    end else begin
      row_q <= row_d;
    end
  end

  assign row_o = row_q;

endmodule

### rtl/lag_life_rule.sv
// ----------------------------------------------------------------------------
// lag_life_rule
// Next generation of one row from a three-row window, with change flag.
// ----------------------------------------------------------------------------
module lag_life_rule import lag_pkg::*; #(
  parameter int MAX_COLS = MaxColsDef
) (
  input  rule_ctl_t           ctl_i,
  input  logic [MAX_COLS-1:0] prev_i,
  input  logic [MAX_COLS-1:0] cur_i,
  input  logic [MAX_COLS-1:0] next_i,
  output logic [MAX_COLS-1:0] row_o,
  output logic                changed_o
);

  for (genvar c = 0; c < MAX_COLS; c++) begin : g_col
    if (c == 0 || c == MAX_COLS - 1) begin : g_edge
      assign row_o[c] = cur_i[c];
    end else begin : g_in
      logic [3:0] cnt;
      logic       nxt;
      logic       active;

      assign cnt = {3'b0, prev_i[c-1]} + {3'b0, prev_i[c]} + {3'b0, prev_i[c+1]}
                 + {3'b0, cur_i[c-1]}  + {3'b0, cur_i[c+1]}
                 + {3'b0, next_i[c-1]} + {3'b0, next_i[c]} + {3'b0, next_i[c+1]};
      assign nxt    = cur_i[c] ? (cnt == LiveKeep || cnt == LiveBorn) : (cnt == LiveBorn);
      // interior column: c+1 below the width in use
      assign active = ctl_i.row_active && (DimW'(c + 1) < ctl_i.used_cols);
      assign row_o[c] = active ? nxt : cur_i[c];
    end
  end

  assign changed_o = |(row_o ^ cur_i);

endmodule

### rtl/life_automaton_grid_unit.sv
// ----------------------------------------------------------------------------
// life_automaton_grid_unit
// Conway life grid (b3/s23) held in a ring of row cells.
//
//   channel  direction  handshake                 payload
//   in       in         in_valid_i / in_stall_o   opcode, row_index, col_index, write_value
//   out      out        out_valid_o / out_stall_i cell_value, range_error, live_changed
//   cfg      in         cfg_we_i                  cfg_idx_i, cfg_data_i
//
// Every word takes an accept in the idle state and one full lap of the row
// ring, which rotates one row per cycle past the rule unit at its head while not held.
// Reset clears all cells at once; no clearing pass is needed.
// While a result waits under out_stall_i, the next word holds at its last lap
// step until the output register frees.
// ----------------------------------------------------------------------------
module life_automaton_grid_unit import lag_pkg::*; #(
  parameter int MAX_COLS = MaxColsDef,
  parameter int MAX_ROWS = MaxRowsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [1:0]      opcode_i,
  input  logic [5:0]      row_index_i,
  input  logic [5:0]      col_index_i,
  input  logic            write_value_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic            cell_value_o,
  output logic            range_error_o,
  output logic            live_changed_o,
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [CfgW-1:0] cfg_data_i
);

  localparam int RCW = $clog2(MAX_ROWS);
  localparam int CIW = $clog2(MAX_COLS);

  ctl_state_e state_q, state_d;

  logic [CfgW-1:0] grid_width_q, grid_height_q;
  logic [DimW-1:0] used_cols, used_rows;

  logic [RCW-1:0]  lap_q, lap_d;
  op_e             op_q;
  logic [5:0]      row_q, col_q;
  logic            val_q;
  logic            rd_q, rd_d, chg_q, chg_d;
  logic            out_valid_q, out_valid_d;
  logic            cell_q, range_q, live_q;

  logic            accept, last, rot_en, fin;
  logic            in_range, row_hit, rd_hit, chg_hit, is_access;
  logic [CIW-1:0]  col_sel;

  logic [MAX_COLS-1:0] rows_w [MAX_ROWS];
  logic [MAX_COLS-1:0] head, head_wr, head_new, rule_row, prev_q;
  logic                rule_chg;
  rule_ctl_t           rule_ctl;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= CfgDimRst;
      grid_height_q <= CfgDimRst;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_GRID_WIDTH:  grid_width_q  <= cfg_data_i;
        REG_GRID_HEIGHT: grid_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign used_cols = clamp_dim(grid_width_q, DimW'(MAX_COLS));
  assign used_rows = clamp_dim(grid_height_q, DimW'(MAX_ROWS));

  // row ring
  for (genvar i = 0; i < MAX_ROWS; i++) begin : g_row
    logic [MAX_COLS-1:0] feed;
    if (i == MAX_ROWS - 1) begin : g_tail
      assign feed = head_new;
    end else begin : g_mid
      assign feed = rows_w[i+1];
    end
    lag_row_cell #(.MAX_COLS(MAX_COLS)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (rot_en),
      .row_i   (feed),
      .row_o   (rows_w[i])
    );
  end

  assign head = rows_w[0];

  assign rule_ctl = '{
    row_active: (lap_q != '0) && ((DimW'(lap_q) + DimW'(1)) < used_rows),
    used_cols:  used_cols
  };

  lag_life_rule #(.MAX_COLS(MAX_COLS)) u_rule (
    .ctl_i     (rule_ctl),
    .prev_i    (prev_q),
    .cur_i     (head),
    .next_i    (rows_w[1]),
    .row_o     (rule_row),
    .changed_o (rule_chg)
  );

  // access decode
  assign col_sel   = CIW'(col_q);
  assign in_range  = (DimW'(row_q) < used_rows) && (DimW'(col_q) < used_cols);
  assign row_hit   = in_range && (DimW'(lap_q) == DimW'(row_q));
  assign is_access = (op_q == OP_WRITE) || (op_q == OP_READ);

  always_comb begin
    head_wr          = head;
    head_wr[col_sel] = val_q;
  end

  always_comb begin
    head_new = head;
    rd_hit   = 1'b0;
    chg_hit  = 1'b0;
    case (op_q)
      OP_WRITE: begin
        if (row_hit) head_new = head_wr;
      end
      OP_READ: begin
        rd_hit = row_hit;
      end
      OP_ADVANCE: begin
        head_new = rule_row;
        chg_hit  = rule_chg;
      end
      default: ;
    endcase
  end

  assign rd_d  = rd_q | (rd_hit & head[col_sel]);
  assign chg_d = chg_q | chg_hit;

  // sequencer: next state
  assign last = (lap_q == RCW'(MAX_ROWS - 1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_RUN;
      end
      ST_RUN: begin
        if (fin) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    in_stall_o = 1'b1;
    rot_en     = 1'b0;
    fin        = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
      end
      ST_RUN: begin
        // hold the last step while the previous result still waits
        rot_en = !(last && out_valid_q && out_stall_i);
        fin    = rot_en && last;
      end
      default: ;
    endcase
  end

  assign accept = in_valid_i && !in_stall_o;
  assign lap_d  = accept ? '0 : (rot_en ? lap_q + RCW'(1) : lap_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      lap_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lap_q       <= lap_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_d = fin || (out_valid_q && out_stall_i);

  // item word and accumulators
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= op_e'(opcode_i);
      row_q <= row_index_i;
      col_q <= col_index_i;
      val_q <= write_value_i;
      rd_q  <= 1'b0;
      chg_q <= 1'b0;
    end else if (rot_en) begin
      rd_q  <= rd_d;
      chg_q <= chg_d;
    end
    if (rot_en) begin
      prev_q <= head;
    end
    if (fin) begin
      cell_q  <= rd_d;
      range_q <= is_access && !in_range;
      live_q  <= chg_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign cell_value_o   = cell_q;
  assign range_error_o  = range_q;
  assign live_changed_o = live_q;

endmodule

### rtl/lag_checker.sv
// ----------------------------------------------------------------------------
// lag_checker
// Port-level checks of the life automaton grid, bound to the top level.
// ----------------------------------------------------------------------------
module lag_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_stall_o,
  input logic [1:0]      opcode_i,
  input logic [5:0]      row_index_i,
  input logic [5:0]      col_index_i,
  input logic            write_value_i,
  input logic            out_valid_o,
  input logic            out_stall_i,
  input logic            cell_value_o,
  input logic            range_error_o,
  input logic            live_changed_o
);

  // an accepted word keeps the block busy for the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while a word is in work");

  // a new result only appears at the end of a busy lap
  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a word in work");

  // at most one flag per result word
  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot0({cell_value_o, range_error_o, live_changed_o}))
    else $error("conflicting result flags");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o &&
      $stable({cell_value_o, range_error_o, live_changed_o}))
    else $error("stalled result changed");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i &&
      $stable({opcode_i, row_index_i, col_index_i, write_value_i}))
    else $error("stalled input word changed");

endmodule

bind life_automaton_grid_unit lag_checker u_lag_checker (.*);
